>>> rtl/core/pds_pkg.sv
// package for the phong diffuse/specular shader: field widths, queue word layout,
// register index codes and the configuration struct
// no dependencies
package pds_pkg;

  localparam int COLOR_FRAC_DEF = 15;
  localparam int VEC_FRAC_DEF   = 14;

  localparam int FIELD_W = 16;
  localparam int IN_W    = 12 * FIELD_W;
  localparam int OUT_W   = 3 * FIELD_W;

  // queue word, low to high: dln (33-V bits), x (V+1 bits), has_spec, black, surface rgb
  localparam int Q_HS    = 34;
  localparam int Q_BLK   = 35;
  localparam int Q_SURF  = 36;
  localparam int QUEUE_W = Q_SURF + 3 * FIELD_W;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_RED,
    REG_LIGHT_GREEN,
    REG_LIGHT_BLUE,
    REG_LIGHT_INTENSITY,
    REG_DIFFUSE_RATIO,
    REG_SPECULAR_RATIO,
    REG_SHININESS
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] light_red;
    logic [15:0] light_green;
    logic [15:0] light_blue;
    logic [15:0] light_intensity;
    logic [15:0] diffuse_ratio;
    logic [15:0] specular_ratio;
    logic [7:0]  shininess;
  } shade_cfg_t;

  localparam logic [15:0] RST_LIGHT     = 16'd32768;
  localparam logic [15:0] RST_RATIO     = 16'd29491;
  localparam logic [7:0]  RST_SHININESS = 8'd200;

endpackage

>>> rtl/core/pds_front.sv
// front pipeline of the shader: takes requests, forms the light-normal dot,
// the reflection and the clamped reflection-eye dot, and pushes into the queue
// depends on pds_pkg
module pds_front #(
  parameter int VECTOR_FRAC_BITS = pds_pkg::VEC_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pds_pkg::IN_W-1:0]    in_data,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [pds_pkg::QUEUE_W-1:0] q_data
);
  import pds_pkg::*;

  localparam int V     = VECTOR_FRAC_BITS;
  localparam int DLN_W = 34 - V;
  localparam int M_W   = DLN_W + 17;
  localparam int R_W   = ((52 - 2 * V) > 16 ? (52 - 2 * V) : 16) + 1;
  localparam int P_W   = R_W + 16;
  localparam int RE_W  = R_W + 18;
  localparam int NS    = 8;

  localparam logic signed [33:0]   HALF_DL = 34'sd1 <<< (V - 1);
  localparam logic signed [M_W-1:0] HALF_M = M_W'(1) <<< (V - 1);
  localparam logic signed [RE_W:0] HALF_X  = (RE_W + 1)'(1) <<< (V - 1);
  localparam logic signed [RE_W:0] ONE_X   = (RE_W + 1)'(1) <<< V;

  logic          adv;
  logic [NS-1:0] v_r;

  logic signed [15:0] l0_r [3];
  logic signed [15:0] n0_r [3];
  logic signed [15:0] e0_r [3];
  logic [47:0]        surf_r [NS];

  logic signed [32:0] dot1_r;
  logic signed [15:0] l1_r [3];
  logic signed [15:0] n1_r [3];
  logic signed [15:0] e1_r [3];

  logic signed [DLN_W-1:0] dln_r [2:7];
  logic                    blk_r [2:7];
  logic signed [15:0]      l2_r [3];
  logic signed [15:0]      n2_r [3];
  logic signed [15:0]      e2_r [3];

  logic signed [M_W-1:0] m3_r [3];
  logic signed [15:0]    l3_r [3];
  logic signed [15:0]    e3_r [3];

  logic signed [R_W-1:0] r4_r [3];
  logic signed [15:0]    e4_r [3];

  logic signed [P_W-1:0]  p5_r [3];
  logic signed [RE_W-1:0] re6_r;
  logic [V:0]             x7_r;
  logic                   hs7_r;

  logic signed [32:0]      dot_nxt;
  logic signed [33:0]      dl_sum;
  logic signed [DLN_W-1:0] dln_nxt;
  logic signed [M_W-1:0]   m_nxt [3];
  logic signed [M_W-1:0]   rs_sum [3];
  logic signed [R_W-1:0]   r_nxt [3];
  logic signed [P_W-1:0]   p_nxt [3];
  logic signed [RE_W-1:0]  re_nxt;
  logic signed [RE_W:0]    xs_sum;
  logic signed [RE_W:0]    xs_sh;
  logic [V:0]              x_nxt;

  assign adv      = !q_full;
  assign in_ready = adv;
  assign q_push   = adv && v_r[NS-1];
  assign q_data   = {surf_r[NS-1], blk_r[7], hs7_r, x7_r, dln_r[7][32-V:0]};

  always_comb begin
    dot_nxt = 33'(l0_r[0]) * 33'(n0_r[0]) + 33'(l0_r[1]) * 33'(n0_r[1])
            + 33'(l0_r[2]) * 33'(n0_r[2]);
    dl_sum  = 34'(dot1_r) + HALF_DL;
    dln_nxt = DLN_W'(dl_sum >>> V);
    for (int i = 0; i < 3; i++) begin
      // reflection r = 2 (l.n) n - l
      m_nxt[i]  = (M_W'(dln_r[2]) * M_W'(n2_r[i])) <<< 1;
      rs_sum[i] = m3_r[i] + HALF_M;
      r_nxt[i]  = R_W'(rs_sum[i] >>> V) - R_W'(l3_r[i]);
      p_nxt[i]  = P_W'(r4_r[i]) * P_W'(e4_r[i]);
    end
    re_nxt = RE_W'(p5_r[0]) + RE_W'(p5_r[1]) + RE_W'(p5_r[2]);
    xs_sum = (RE_W + 1)'(re6_r) + HALF_X;
    xs_sh  = xs_sum >>> V;
    // clamp to [0, 1.0]
    if (xs_sh < 0) begin
      x_nxt = '0;
    end else if (xs_sh > ONE_X) begin
      x_nxt = {1'b1, V'(0)};
    end else begin
      x_nxt = (V + 1)'(xs_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        l0_r[i] <= in_data[16*i +: 16];
        n0_r[i] <= in_data[16*(3+i) +: 16];
        e0_r[i] <= in_data[16*(6+i) +: 16];
        l1_r[i] <= l0_r[i];
        n1_r[i] <= n0_r[i];
        e1_r[i] <= e0_r[i];
        l2_r[i] <= l1_r[i];
        n2_r[i] <= n1_r[i];
        e2_r[i] <= e1_r[i];
        m3_r[i] <= m_nxt[i];
        l3_r[i] <= l2_r[i];
        e3_r[i] <= e2_r[i];
        r4_r[i] <= r_nxt[i];
        e4_r[i] <= e3_r[i];
        p5_r[i] <= p_nxt[i];
      end
      surf_r[0] <= in_data[16*9 +: 48];
      for (int s = 1; s < NS; s++) begin
        surf_r[s] <= surf_r[s-1];
      end
      dot1_r   <= dot_nxt;
      dln_r[2] <= dln_nxt;
      blk_r[2] <= dot1_r[32];
      for (int s = 3; s < NS; s++) begin
        dln_r[s] <= dln_r[s-1];
        blk_r[s] <= blk_r[s-1];
      end
      re6_r <= re_nxt;
      x7_r  <= x_nxt;
      hs7_r <= re6_r > 0;
    end
  end

endmodule

>>> rtl/core/pds_fifo.sv
// short register queue between the front and back pipelines
// depends on pds_pkg
module pds_fifo #(
  parameter int W     = pds_pkg::QUEUE_W,
  parameter int DEPTH = pds_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import pds_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = cnt_r == (AW + 1)'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/pds_back.sv
// back pipeline of the shader: specular power by square and multiply, one
// exponent bit a stage, effective color, diffuse plus specular and saturation
// depends on pds_pkg
module pds_back #(
  parameter int COLOR_FRAC_BITS  = pds_pkg::COLOR_FRAC_DEF,
  parameter int VECTOR_FRAC_BITS = pds_pkg::VEC_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pds_pkg::shade_cfg_t         cfg,
  input  logic                        q_empty,
  input  logic [pds_pkg::QUEUE_W-1:0] q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pds_pkg::OUT_W-1:0]   out_data
);
  import pds_pkg::*;

  localparam int C      = COLOR_FRAC_BITS;
  localparam int V      = VECTOR_FRAC_BITS;
  localparam int NS     = 11;
  localparam int DLN_U  = 33 - V;
  localparam int PW_S   = 2 * V + 2;
  localparam int T1_S   = 33;
  localparam int T1_W   = T1_S - C;
  localparam int EF_S   = T1_W + 17;
  localparam int EFF_W  = EF_S - C;
  localparam int ER_S   = EFF_W + 17;
  localparam int ER_W   = ER_S - C;
  localparam int DF_S   = (ER_W + DLN_U + 1 > 64) ? 64 : ER_W + DLN_U + 1;
  localparam int DF_W   = DF_S - V;
  localparam int SP_S   = (ER_W + V + 2 > 64) ? 64 : ER_W + V + 2;
  localparam int SP_W   = SP_S - V;
  localparam int SUM_M  = (DF_W > SP_W) ? DF_W : SP_W;
  localparam int SUM_W  = ((SUM_M > 16) ? SUM_M : 16) + 1;

  localparam logic [PW_S-1:0] PW_HALF = PW_S'(1) << (V - 1);
  localparam logic [T1_S-1:0] T1_HALF = T1_S'(1) << (C - 1);
  localparam logic [EF_S-1:0] EF_HALF = EF_S'(1) << (C - 1);
  localparam logic [ER_S-1:0] ER_HALF = ER_S'(1) << (C - 1);
  localparam logic [DF_S-1:0] DF_HALF = DF_S'(1) << (V - 1);
  localparam logic [SP_S-1:0] SP_HALF = SP_S'(1) << (V - 1);
  localparam logic [SUM_W-1:0] SAT    = SUM_W'(16'hFFFF);

  logic          adv;
  logic [NS-1:0] v_r;

  logic [DLN_U-1:0] dln_r [NS];
  logic             hs_r  [NS];
  logic             blk_r [NS];
  logic [V:0]       acc_r  [9];
  logic [V:0]       base_r [9];
  logic [15:0]      surf_r [3];
  logic [T1_W-1:0]  t1_r   [3];
  logic [EFF_W-1:0] eff_r  [3];
  logic [ER_W-1:0]  ed_r   [3:8][3];
  logic [ER_W-1:0]  es_r   [3:8][3];
  logic [DF_W-1:0]  df_r   [3];
  logic [SP_W-1:0]  sp_r   [3];
  logic [15:0]      out_r  [3];

  logic [15:0]      lc [3];
  logic [PW_S-1:0]  pa_sum [8];
  logic [PW_S-1:0]  pb_sum [8];
  logic [T1_S-1:0]  t1_sum [3];
  logic [EF_S-1:0]  ef_sum [3];
  logic [ER_S-1:0]  ed_sum [3];
  logic [ER_S-1:0]  es_sum [3];
  logic [DF_S-1:0]  df_sum [3];
  logic [SP_S-1:0]  sp_sum [3];
  logic [SUM_W-1:0] tot    [3];
  logic [15:0]      out_nxt [3];

  assign adv       = !v_r[NS-1] || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = v_r[NS-1];
  assign out_data  = {out_r[2], out_r[1], out_r[0]};

  assign lc[0] = cfg.light_red;
  assign lc[1] = cfg.light_green;
  assign lc[2] = cfg.light_blue;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pa_sum[k] = PW_S'(acc_r[k]) * PW_S'(base_r[k]) + PW_HALF;
      pb_sum[k] = PW_S'(base_r[k]) * PW_S'(base_r[k]) + PW_HALF;
    end
    for (int c = 0; c < 3; c++) begin
      t1_sum[c] = T1_S'(lc[c]) * T1_S'(surf_r[c]) + T1_HALF;
      ef_sum[c] = EF_S'(t1_r[c]) * EF_S'(cfg.light_intensity) + EF_HALF;
      ed_sum[c] = ER_S'(eff_r[c]) * ER_S'(cfg.diffuse_ratio) + ER_HALF;
      es_sum[c] = ER_S'(eff_r[c]) * ER_S'(cfg.specular_ratio) + ER_HALF;
      // products wrap at 64 bits for extreme fraction widths
      df_sum[c] = DF_S'(ed_r[8][c]) * DF_S'(dln_r[8]) + DF_HALF;
      sp_sum[c] = SP_S'(es_r[8][c]) * SP_S'(acc_r[8]) + SP_HALF;
      tot[c]    = SUM_W'(df_r[c]) + SUM_W'(sp_r[c]);
      if (blk_r[9]) begin
        out_nxt[c] = '0;
      end else if (tot[c] > SAT) begin
        out_nxt[c] = 16'hFFFF;
      end else begin
        out_nxt[c] = 16'(tot[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dln_r[0]  <= q_data[DLN_U-1:0];
      base_r[0] <= q_data[Q_HS-1 -: V+1];
      acc_r[0]  <= {1'b1, V'(0)};
      hs_r[0]   <= q_data[Q_HS];
      blk_r[0]  <= q_data[Q_BLK];
      for (int c = 0; c < 3; c++) begin
        surf_r[c] <= q_data[Q_SURF + 16*c +: 16];
        t1_r[c]   <= T1_W'(t1_sum[c] >> C);
        eff_r[c]  <= EFF_W'(ef_sum[c] >> C);
        ed_r[3][c] <= ER_W'(ed_sum[c] >> C);
        es_r[3][c] <= ER_W'(es_sum[c] >> C);
        for (int s = 4; s <= 8; s++) begin
          ed_r[s][c] <= ed_r[s-1][c];
          es_r[s][c] <= es_r[s-1][c];
        end
        df_r[c]  <= DF_W'(df_sum[c] >> V);
        sp_r[c]  <= hs_r[8] ? SP_W'(sp_sum[c] >> V) : '0;
        out_r[c] <= out_nxt[c];
      end
      for (int s = 1; s < NS; s++) begin
        dln_r[s] <= dln_r[s-1];
        hs_r[s]  <= hs_r[s-1];
        blk_r[s] <= blk_r[s-1];
      end
      // one exponent bit per stage, lsb first
      for (int k = 0; k < 8; k++) begin
        acc_r[k+1]  <= cfg.shininess[k] ? (V + 1)'(pa_sum[k] >> V) : acc_r[k];
        base_r[k+1] <= (V + 1)'(pb_sum[k] >> V);
      end
    end
  end

endmodule

>>> rtl/core/phong_diffuse_specular_shade.sv
// phong diffuse plus specular shader, top level: configuration registers,
// front pipeline, queue and back pipeline
// depends on pds_pkg, pds_front, pds_fifo, pds_back
//
// usage:
//   in_* is a stream of shading requests, one surface point and one light each;
//   out_* returns one rgb result per request, in request order.
//   cfg_we/cfg_index/cfg_wdata write the light color, intensity, material
//   ratios and shininess; write only while no request is in flight.
//   throughput is one request per cycle when out_tready stays high.
//   with no stall a request passes 8 front stages (dot products, reflection,
//   clamp), the queue, and 11 back stages (8 for the square-and-multiply
//   power, then color and saturation). when out_tready drops the back
//   pipeline holds; the front keeps taking requests until the 4-entry
//   queue fills, then in_tready falls.
//   reset clears all valid state and loads the register defaults.
module phong_diffuse_specular_shade #(
  parameter int COLOR_FRAC_BITS  = pds_pkg::COLOR_FRAC_DEF,
  parameter int VECTOR_FRAC_BITS = pds_pkg::VEC_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // light_dir_x/y/z, normal_x/y/z, eye_x/y/z, surface_red/green/blue
  input  logic [pds_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // red_out, green_out, blue_out
  output logic [pds_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_we,
  input  logic [pds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata
);
  import pds_pkg::*;

  shade_cfg_t           cfg_r;
  logic                 q_full, q_empty, q_push, q_pop;
  logic [QUEUE_W-1:0]   q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_red       <= RST_LIGHT;
      cfg_r.light_green     <= RST_LIGHT;
      cfg_r.light_blue      <= RST_LIGHT;
      cfg_r.light_intensity <= RST_LIGHT;
      cfg_r.diffuse_ratio   <= RST_RATIO;
      cfg_r.specular_ratio  <= RST_RATIO;
      cfg_r.shininess       <= RST_SHININESS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIGHT_RED:       cfg_r.light_red       <= cfg_wdata;
        REG_LIGHT_GREEN:     cfg_r.light_green     <= cfg_wdata;
        REG_LIGHT_BLUE:      cfg_r.light_blue      <= cfg_wdata;
        REG_LIGHT_INTENSITY: cfg_r.light_intensity <= cfg_wdata;
        REG_DIFFUSE_RATIO:   cfg_r.diffuse_ratio   <= cfg_wdata;
        REG_SPECULAR_RATIO:  cfg_r.specular_ratio  <= cfg_wdata;
        REG_SHININESS:       cfg_r.shininess       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  pds_front #(
    .VECTOR_FRAC_BITS(VECTOR_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  pds_fifo #(
    .W     (QUEUE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  pds_back #(
    .COLOR_FRAC_BITS  (COLOR_FRAC_BITS),
    .VECTOR_FRAC_BITS (VECTOR_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

>>> bench/testbench.sv
// self-checking bench for phong_diffuse_specular_shade: random shading requests,
// register settings and handshake stalls, results checked against a local predictor
// depends on pds_pkg and the shader rtl
`timescale 1ns / 100ps

module testbench;
  import pds_pkg::*;

  localparam int CF = COLOR_FRAC_DEF;
  localparam int VF = VEC_FRAC_DEF;
  localparam int LATENCY = 20;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] ld [3];
    logic signed [15:0] nrm [3];
    logic signed [15:0] eye [3];
    logic [15:0] surf [3];
  } shade_req_t;

  typedef struct {
    logic [15:0] rgb [3];
  } shade_rgb_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  phong_diffuse_specular_shade uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  shade_cfg_t cfg_shadow;
  shade_req_t pending_reqs[$];
  shade_rgb_t expected_rgb[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_sender = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  function automatic longint sround(longint x, int s);
    longint y;
    y = x + (longint'(1) << (s - 1));
    return y >>> s;
  endfunction

  function automatic longint uround(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >> s;
  endfunction

  function automatic shade_rgb_t shade_point(shade_req_t q);
    shade_rgb_t res;
    longint dot_ln, dot_re, dln, x, pw, base, eff, dif, spc, sum;
    longint lc [3];
    bit spec_on;
    dot_ln = 0;
    dot_re = 0;
    pw = 0;
    lc[0] = longint'(cfg_shadow.light_red);
    lc[1] = longint'(cfg_shadow.light_green);
    lc[2] = longint'(cfg_shadow.light_blue);
    for (int i = 0; i < 3; i++) dot_ln += longint'(q.ld[i]) * longint'(q.nrm[i]);
    if (dot_ln < 0) begin
      for (int i = 0; i < 3; i++) res.rgb[i] = '0;
      return res;
    end
    dln = sround(dot_ln, VF);
    for (int i = 0; i < 3; i++)
      dot_re += (sround(2 * dln * longint'(q.nrm[i]), VF) - longint'(q.ld[i]))
                * longint'(q.eye[i]);
    spec_on = dot_re > 0;
    if (spec_on) begin
      x = sround(dot_re, VF);
      if (x < 0) x = 0;
      if (x > (longint'(1) << VF)) x = longint'(1) << VF;
      pw = longint'(1) << VF;
      base = x;
      for (int b = 0; b < 8; b++) begin
        if (cfg_shadow.shininess[b]) pw = uround(pw * base, VF);
        base = uround(base * base, VF);
      end
    end
    for (int i = 0; i < 3; i++) begin
      eff = uround(uround(lc[i] * longint'(q.surf[i]), CF) * cfg_shadow.light_intensity, CF);
      dif = uround(uround(eff * cfg_shadow.diffuse_ratio, CF) * dln, VF);
      spc = spec_on ? uround(uround(eff * cfg_shadow.specular_ratio, CF) * pw, VF) : 0;
      sum = dif + spc;
      res.rgb[i] = (sum > 65535) ? 16'hFFFF : sum[15:0];
    end
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_req(shade_req_t q);
    logic [IN_W-1:0] w;
    for (int i = 0; i < 3; i++) begin
      w[16*i +: 16] = q.ld[i];
      w[16*(3+i) +: 16] = q.nrm[i];
      w[16*(6+i) +: 16] = q.eye[i];
      w[16*(9+i) +: 16] = q.surf[i];
    end
    return w;
  endfunction

  function automatic logic signed [15:0] rand_vec();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] rand_color();
    case ($urandom_range(0, 7))
      0: return 16'd32768;
      1: return 16'd0;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // mostly near-unit vectors with eye near the reflection so the power is nonzero
  function automatic shade_req_t rand_req();
    shade_req_t q;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      q.ld[i] = rand_vec();
      q.nrm[i] = rand_vec();
      q.eye[i] = rand_vec();
      q.surf[i] = rand_color();
    end
    if (mode != 0) begin
      q.nrm[0] = '0; q.nrm[1] = '0; q.nrm[2] = 16'sd16384;
      q.ld[2] = 16'($urandom_range(0, 16384));
      q.ld[0] = 16'($signed($urandom_range(0, 8000)) - 4000);
      q.ld[1] = 16'($signed($urandom_range(0, 8000)) - 4000);
      q.eye[0] = -q.ld[0] + 16'($signed($urandom_range(0, 200)) - 100);
      q.eye[1] = -q.ld[1] + 16'($signed($urandom_range(0, 200)) - 100);
      q.eye[2] = q.ld[2];
    end
    return q;
  endfunction

  function automatic shade_req_t make_req(int lx, int ly, int lz, int nx, int ny, int nz,
                                          int ex, int ey, int ez, int c);
    shade_req_t q;
    q.ld[0] = 16'(lx); q.ld[1] = 16'(ly); q.ld[2] = 16'(lz);
    q.nrm[0] = 16'(nx); q.nrm[1] = 16'(ny); q.nrm[2] = 16'(nz);
    q.eye[0] = 16'(ex); q.eye[1] = 16'(ey); q.eye[2] = 16'(ez);
    for (int i = 0; i < 3; i++) q.surf[i] = 16'(c);
    return q;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // driver: bursts with gaps
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      expected_rgb.push_back(shade_point(pending_reqs.pop_front()));
    end
    if (in_tvalid && !in_tready) begin
      // hold the request
    end else if (!rst_n || hold_sender || pending_reqs.size() == 0 ||
                 (in_tvalid && in_tready && pending_reqs.size() == 0)) begin
      in_tvalid <= 0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_tvalid <= 0;
    end else begin
      in_tvalid <= 1;
      in_tdata <= pack_req(pending_reqs[0]);
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    shade_rgb_t want;
    stall_phase <= stall_phase + 1;
    if (stall_phase[8]) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 3) != 0);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (out_tvalid && out_tready) begin
      if (expected_rgb.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[15:0], '0);
      end else begin
        want = expected_rgb.pop_front();
        for (int i = 0; i < 3; i++)
          if (out_tdata[16*i +: 16] !== want.rgb[i])
            report_mismatch($sformatf("channel %0d", i), out_tdata[16*i +: 16], want.rgb[i]);
      end
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_rgb.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LIGHT_RED: cfg_shadow.light_red = val;
      REG_LIGHT_GREEN: cfg_shadow.light_green = val;
      REG_LIGHT_BLUE: cfg_shadow.light_blue = val;
      REG_LIGHT_INTENSITY: cfg_shadow.light_intensity = val;
      REG_DIFFUSE_RATIO: cfg_shadow.diffuse_ratio = val;
      REG_SPECULAR_RATIO: cfg_shadow.specular_ratio = val;
      default: cfg_shadow.shininess = val[7:0];
    endcase
    @(posedge clk);
  endtask

  initial begin
    cfg_shadow = '{RST_LIGHT, RST_LIGHT, RST_LIGHT, RST_LIGHT, RST_RATIO, RST_RATIO,
                   RST_SHININESS};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: head-on light, light behind, grazing, reflection away, above one
    pending_reqs.push_back(make_req(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 32768));
    pending_reqs.push_back(make_req(0, 0, -16384, 0, 0, 16384, 0, 0, 16384, 32768));
    pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 16384, 32768));
    pending_reqs.push_back(make_req(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 20000));
    pending_reqs.push_back(make_req(11585, 0, 11585, 0, 0, 16384, -11585, 0, 11585, 32768));
    pending_reqs.push_back(make_req(-32768, -32768, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767, 65535));
    pending_reqs.push_back(make_req(32767, 32767, 32767, -32768, -32768, -32768,
                                    -32768, -32768, -32768, 0));
    pending_reqs.push_back(make_req(-16384, -16384, 16384, 16384, 16384, 16384,
                                    16384, 16384, 16384, 65535));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_req());

    // sender waits for every result before going on
    wait (pending_reqs.size() == 0);
    hold_sender = 1;
    drain();
    hold_sender = 0;

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      for (int r = 0; r <= int'(REG_SHININESS); r++) begin
        logic [15:0] v;
        if (r == int'(REG_SHININESS))
          v = (ph == 0) ? 16'd0 : (ph == 1) ? 16'd1 : (ph == 2) ? 16'd255
              : 16'($urandom_range(1, 255));
        else
          v = (ph == 0) ? 16'd32768 : (ph == 1) ? 16'd0 : (ph == 2) ? 16'hFFFF
              : (ph == 3) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        write_reg(cfg_reg_t'(r), v);
      end
      cfg_we <= 0;
      for (int i = 0; i < 140; i++) pending_reqs.push_back(rand_req());
    end
    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
